// ===== sv/chb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chb_pkg
// Types and codes shared by the clamped histogram binner.
// ----------------------------------------------------------------------------
package chb_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int READ_BIN_W = 6;
  localparam int BIN_NUM_W  = 6;
  localparam int TOTAL_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int BINS_W     = 7;
  localparam int STEP_W     = 4;

  localparam int IN_TDATA_W  = 24;  // sample + read_bin, padded to bytes
  localparam int OUT_TDATA_W = 40;  // bin_number + bin_total, padded to bytes

  typedef logic [CFG_IDX_W-1:0] cfg_index_t;

  localparam cfg_index_t REG_LOWER_BOUND = 3'd0;
  localparam cfg_index_t REG_UPPER_BOUND = 3'd1;
  localparam cfg_index_t REG_BIN_WIDTH   = 3'd2;
  localparam cfg_index_t REG_BINS_IN_USE = 3'd3;

  localparam logic CMD_COUNT = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIVIDE,
    ST_PICK,
    ST_FETCH,
    ST_UPDATE
  } chb_state_t;

endpackage

// ===== sv/clamped_histogram_binner_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clamped_histogram_binner_unit
// Uniform-bin histogram of signed Q8.8 samples with saturating bin counts.
// ----------------------------------------------------------------------------
// One item is handled at a time and every item returns one result. A count
// item whose sample lies strictly between the bounds, with a non-zero bin
// width, goes through 16 steps of the restoring divider (one quotient bit a
// cycle), a step to clamp the bin, the bin memory read and the write-back,
// which waits for a free output register, and then back to idle to take the
// next request. A count item settled by the bounds, and a read item, skip the
// divider and the clamp. The result sits in an output register, so a new
// request is taken while it waits. After reset the bin memory is zeroed by a
// clearing pass over all MAX_BINS words during which no request is taken;
// configuration writes are accepted at all times.
// ----------------------------------------------------------------------------
module clamped_histogram_binner_unit #(
  parameter int MAX_BINS   = 64,
  parameter int COUNT_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  chb_pkg::cfg_index_t               cfg_index,
  input  logic [chb_pkg::CFG_DATA_W-1:0]    cfg_data,
  // requests
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [chb_pkg::IN_TDATA_W-1:0]    in_tdata,   // [15:0] sample, [21:16] read_bin
  input  logic                              in_tuser,   // [0] cmd
  // results
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [chb_pkg::OUT_TDATA_W-1:0]   out_tdata   // [5:0] bin_number, [37:6] bin_total
);

  import chb_pkg::*;

  localparam int ADDR_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam logic [ADDR_W-1:0]     LAST_ADDR = ADDR_W'(MAX_BINS - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // configuration registers
  logic signed [SAMPLE_W-1:0] lower_r;
  logic signed [SAMPLE_W-1:0] upper_r;
  logic [SAMPLE_W-1:0]        width_r;
  logic [BINS_W-1:0]          bins_r;

  // control
  chb_state_t        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic              is_read_r, is_read_nxt;
  logic              oor_r, oor_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [BIN_NUM_W-1:0] num_r, num_nxt;
  logic [SAMPLE_W-1:0]  rem_r, rem_nxt;
  logic [SAMPLE_W-1:0]  quo_r, quo_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [BIN_NUM_W-1:0] out_num_r, out_num_nxt;
  logic [TOTAL_W-1:0]   out_total_r, out_total_nxt;

  // memory port
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [COUNT_BITS-1:0] ram_rdata;

  // datapath
  logic signed [SAMPLE_W-1:0] in_sample;
  logic [READ_BIN_W-1:0]      in_read_bin;
  logic                       in_cmd;
  logic [SAMPLE_W:0]          offset;
  logic [ADDR_W-1:0]          last_bin;
  logic [SAMPLE_W:0]          trial;
  logic [SAMPLE_W:0]          trial_diff;
  logic                       trial_ok;
  logic [COUNT_BITS-1:0]      count_inc;
  logic                       out_free;

  assign in_sample   = signed'(in_tdata[SAMPLE_W-1:0]);
  assign in_read_bin = in_tdata[SAMPLE_W +: READ_BIN_W];
  assign in_cmd      = in_tuser;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - TOTAL_W - BIN_NUM_W)'(0), out_total_r, out_num_r};
  assign out_free   = !out_valid_r || out_tready;

  // last active bin: zero bins acts as one, too many acts as MAX_BINS
  always_comb begin
    if (bins_r == '0) begin
      last_bin = '0;
    end else if (32'(bins_r) > 32'(MAX_BINS)) begin
      last_bin = LAST_ADDR;
    end else begin
      last_bin = ADDR_W'(bins_r - BINS_W'(1));
    end
  end

  assign offset = {in_sample[SAMPLE_W-1], in_sample} - {lower_r[SAMPLE_W-1], lower_r};

  // one restoring divide step
  assign trial      = {rem_r, quo_r[SAMPLE_W-1]};
  assign trial_diff = trial - {1'b0, width_r};
  assign trial_ok   = !trial_diff[SAMPLE_W];

  assign count_inc = (ram_rdata == COUNT_MAX) ? ram_rdata : ram_rdata + COUNT_BITS'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r <= '0;
      upper_r <= 16'sd32767;
      width_r <= 16'd512;
      bins_r  <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOWER_BOUND: lower_r <= signed'(cfg_data);
        REG_UPPER_BOUND: upper_r <= signed'(cfg_data);
        REG_BIN_WIDTH:   width_r <= cfg_data;
        REG_BINS_IN_USE: bins_r  <= cfg_data[BINS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_read_r   <= is_read_nxt;
    oor_r       <= oor_nxt;
    addr_r      <= addr_nxt;
    num_r       <= num_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    step_r      <= step_nxt;
    out_num_r   <= out_num_nxt;
    out_total_r <= out_total_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    is_read_nxt   = is_read_r;
    oor_nxt       = oor_r;
    addr_nxt      = addr_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    out_num_nxt   = out_num_r;
    out_total_nxt = out_total_r;
    ram_we        = 1'b0;
    ram_waddr     = addr_r;
    ram_wdata     = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_tvalid) begin
          is_read_nxt = (in_cmd == CMD_READ);
          oor_nxt     = 1'b0;
          if (in_cmd == CMD_READ) begin
            oor_nxt   = 32'(in_read_bin) >= 32'(MAX_BINS);
            addr_nxt  = ADDR_W'(in_read_bin);
            num_nxt   = in_read_bin;
            state_nxt = ST_FETCH;
          end else if (in_sample <= lower_r) begin
            addr_nxt  = '0;
            num_nxt   = '0;
            state_nxt = ST_FETCH;
          end else if (in_sample >= upper_r || width_r == '0) begin
            addr_nxt  = last_bin;
            num_nxt   = BIN_NUM_W'(last_bin);
            state_nxt = ST_FETCH;
          end else begin
            rem_nxt   = '0;
            quo_nxt   = offset[SAMPLE_W-1:0];
            step_nxt  = '0;
            state_nxt = ST_DIVIDE;
          end
        end
      end

      ST_DIVIDE: begin
        rem_nxt  = trial_ok ? trial_diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
        quo_nxt  = {quo_r[SAMPLE_W-2:0], trial_ok};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == '1) begin
          state_nxt = ST_PICK;
        end
      end

      ST_PICK: begin
        // clamp a quotient that overshoots the last active bin
        if (quo_r > 16'(last_bin)) begin
          addr_nxt = last_bin;
        end else begin
          addr_nxt = ADDR_W'(quo_r);
        end
        num_nxt   = BIN_NUM_W'(addr_nxt);
        state_nxt = ST_FETCH;
      end

      ST_FETCH: begin
        state_nxt = ST_UPDATE;
      end

      ST_UPDATE: begin
        // hold the result until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_num_nxt   = num_r;
          if (is_read_r) begin
            out_total_nxt = oor_r ? '0 : TOTAL_W'(ram_rdata);
          end else begin
            ram_we        = 1'b1;
            ram_wdata     = count_inc;
            out_total_nxt = TOTAL_W'(count_inc);
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  chb_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(MAX_BINS)
  ) u_bin_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

endmodule

// ===== sv/chb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chb_ram
// Single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module chb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the clamped histogram binner.
// A short directed table covers the bounds, the clamps and the odd register
// values. Phases of random count and read requests follow, each under new
// settings, with bursty input and a stalling result side. Every result is
// checked against a local model of the bin counts.
// ----------------------------------------------------------------------------
module tb;
  import chb_pkg::*;

  localparam int NUM_BINS    = 64;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 200;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 1000000;

  // indexes past the four registers; writes there must be dropped
  localparam cfg_index_t REG_UNUSED_LO = 3'd4;
  localparam cfg_index_t REG_UNUSED_HI = 3'd7;

  typedef enum logic {ROW_REQ, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    cfg_index_t             idx;
    logic [CFG_DATA_W-1:0]  value;
    logic                   cmd;
    logic [SAMPLE_W-1:0]    smp;
    logic [READ_BIN_W-1:0]  rbin;
    logic                   typed;
    logic [BIN_NUM_W-1:0]   want_bin;
    logic [TOTAL_W-1:0]     want_total;
  } stim_row_t;

  typedef struct packed {
    logic [BIN_NUM_W-1:0] bin;
    logic [TOTAL_W-1:0]   total;
  } bin_result_t;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_valid;
  logic                    cfg_ready;
  cfg_index_t              cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata;
  logic                    in_tuser;
  logic                    out_tvalid;
  logic                    out_tready;
  logic [OUT_TDATA_W-1:0]  out_tdata;

  // local copy of the bin memory and the settings
  logic [TOTAL_W-1:0]      hist_counts [NUM_BINS];
  logic signed [15:0]      lo_bound;
  logic signed [15:0]      hi_bound;
  logic [15:0]             width_q88;
  logic [BINS_W-1:0]       bins_reg;

  bin_result_t             expected_bins [$];
  stim_row_t               dir_rows [$];
  int                      errors = 0;
  int                      burst_left = 0;
  int                      cycle_count = 0;
  logic                    hold_request = 1'b0;

  clamped_histogram_binner_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // append one row to the directed table
  function automatic void add_row(stim_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic logic [BIN_NUM_W-1:0] bin_for_sample(logic signed [15:0] smp);
    int lo;
    int hi;
    int s;
    int last;
    int q;
    lo = lo_bound;
    hi = hi_bound;
    s  = smp;
    if (bins_reg == 0)
      last = 0;
    else if (bins_reg > NUM_BINS)
      last = NUM_BINS - 1;
    else
      last = bins_reg - 1;
    // lower bound wins when the bounds cross
    if (s <= lo) return '0;
    if (s >= hi) return last[BIN_NUM_W-1:0];
    if (width_q88 == 0) return last[BIN_NUM_W-1:0];
    q = (s - lo) / int'(width_q88);
    if (q > last) q = last;
    return q[BIN_NUM_W-1:0];
  endfunction

  function automatic stim_row_t req_row(logic cmd, logic [15:0] smp, logic [5:0] rbin,
                                        logic typed, logic [5:0] want_bin,
                                        logic [31:0] want_total);
    stim_row_t r;
    r            = '0;
    r.kind       = ROW_REQ;
    r.cmd        = cmd;
    r.smp        = smp;
    r.rbin       = rbin;
    r.typed      = typed;
    r.want_bin   = want_bin;
    r.want_total = want_total;
    return r;
  endfunction

  function automatic stim_row_t wr_row(cfg_index_t idx, logic [15:0] value);
    stim_row_t r;
    r       = '0;
    r.kind  = ROW_WRITE;
    r.idx   = idx;
    r.value = value;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0d, expected %0d at cycle %0d", what, got, want,
             cycle_count);
    errors++;
  endtask

  // Offer one request in bursts with random gaps, then predict its result.
  task automatic send_item(logic cmd, logic [15:0] smp, logic [5:0] rbin, logic typed,
                           logic [5:0] want_bin, logic [31:0] want_total);
    int                 gap;
    bin_result_t        res;
    logic [5:0]         bin;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {2'b00, rbin, smp};
    do @(posedge clk); while (!in_tready);
    if (cmd == CMD_COUNT) begin
      bin = bin_for_sample(smp);
      if (hist_counts[bin] != '1) hist_counts[bin] = hist_counts[bin] + 1'b1;
    end else begin
      bin = rbin;
    end
    res.bin   = bin;
    res.total = hist_counts[bin];
    if (typed) begin
      res.bin   = want_bin;
      res.total = want_total;
    end
    expected_bins.insert(expected_bins.size(), res);
  endtask

  // Write one register once every outstanding result has come back.
  task automatic write_reg(cfg_index_t idx, logic [15:0] value);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_bins.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_LOWER_BOUND: lo_bound  = value;
      REG_UPPER_BOUND: hi_bound  = value;
      REG_BIN_WIDTH:   width_q88 = value;
      REG_BINS_IN_USE: bins_reg  = value[BINS_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    bin_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_bins.size() == 0) begin
        report_mismatch("result with no request outstanding",
                        out_tdata[BIN_NUM_W +: TOTAL_W], '0);
      end else begin
        want = expected_bins.pop_front();
        if (out_tdata[BIN_NUM_W-1:0] != want.bin)
          report_mismatch("bin_number", 32'(out_tdata[BIN_NUM_W-1:0]), 32'(want.bin));
        if (out_tdata[BIN_NUM_W +: TOTAL_W] != want.total)
          report_mismatch("bin_total", out_tdata[BIN_NUM_W +: TOTAL_W], want.total);
      end
    end
  end

  // Result side: stall in changing styles, with one long hold-off.
  initial begin
    int   style;
    int   style_left;
    logic held;
    style      = 0;
    style_left = 0;
    held       = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !held) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        held = 1'b1;
      end else begin
        if (style_left == 0) begin
          style      = $urandom_range(0, 2);
          style_left = $urandom_range(32, 200);
        end
        style_left--;
        case (style)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  initial begin
    int ph;
    int k;
    int pick;
    int lo_i;
    int hi_i;
    int wid;
    int nb;
    int span;
    int s;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = CMD_COUNT;
    cfg_valid = 1'b0;
    cfg_index = REG_LOWER_BOUND;
    cfg_data  = '0;
    lo_bound  = 16'sd0;
    hi_bound  = 16'sd32767;
    width_q88 = 16'd512;
    bins_reg  = 7'd64;
    foreach (hist_counts[i]) hist_counts[i] = '0;

    // reset settings: bounds 0 and max, width 512, all 64 bins
    add_row(req_row(CMD_READ,  16'h0000, 6'd0,  1'b1, 6'd0,  32'd0));
    add_row(req_row(CMD_READ,  16'hFFFF, 6'd63, 1'b1, 6'd63, 32'd0));
    add_row(req_row(CMD_COUNT, 16'h8000, 6'd63, 1'b1, 6'd0,  32'd1));
    add_row(req_row(CMD_COUNT, 16'h0000, 6'd0,  1'b1, 6'd0,  32'd2));
    add_row(req_row(CMD_COUNT, 16'h7FFF, 6'd0,  1'b1, 6'd63, 32'd1));
    add_row(req_row(CMD_COUNT, 16'h0001, 6'd0,  1'b1, 6'd0,  32'd3));
    add_row(req_row(CMD_COUNT, 16'h7FFE, 6'd0,  1'b1, 6'd63, 32'd2));
    add_row(req_row(CMD_COUNT, 16'd512,  6'd0,  1'b0, 6'd0,  32'd0));
    add_row(req_row(CMD_READ,  16'hFFFF, 6'd1,  1'b1, 6'd1,  32'd1));
    // zero bins in use behaves as one bin; upper data bits are dropped
    add_row(wr_row(REG_BINS_IN_USE, 16'hFF80));
    add_row(req_row(CMD_COUNT, 16'd100,  6'd0,  1'b0, 6'd0,  32'd0));
    add_row(req_row(CMD_COUNT, 16'h7FFF, 6'd0,  1'b0, 6'd0,  32'd0));
    // more bins than exist: hold at the top bin
    add_row(wr_row(REG_BINS_IN_USE, 16'h007F));
    add_row(req_row(CMD_COUNT, 16'h7FFF, 6'd0,  1'b1, 6'd63, 32'd3));
    // zero width sends every interior sample to the last bin
    add_row(wr_row(REG_BIN_WIDTH, 16'h0000));
    add_row(req_row(CMD_COUNT, 16'd100,  6'd0,  1'b0, 6'd0,  32'd0));
    // quotient overshoot: width one over the full range
    add_row(wr_row(REG_BIN_WIDTH, 16'h0001));
    add_row(wr_row(REG_LOWER_BOUND, 16'h8000));
    add_row(req_row(CMD_COUNT, 16'd100,  6'd0,  1'b0, 6'd0,  32'd0));
    add_row(req_row(CMD_COUNT, 16'h8001, 6'd0,  1'b0, 6'd0,  32'd0));
    // bounds equal, then crossed
    add_row(wr_row(REG_LOWER_BOUND, 16'd1000));
    add_row(wr_row(REG_UPPER_BOUND, 16'd1000));
    add_row(req_row(CMD_COUNT, 16'd1000, 6'd0,  1'b0, 6'd0,  32'd0));
    add_row(req_row(CMD_COUNT, 16'd1001, 6'd0,  1'b0, 6'd0,  32'd0));
    add_row(req_row(CMD_COUNT, 16'd999,  6'd0,  1'b0, 6'd0,  32'd0));
    add_row(wr_row(REG_LOWER_BOUND, 16'd500));
    add_row(wr_row(REG_UPPER_BOUND, 16'hFE0C));
    add_row(req_row(CMD_COUNT, 16'h0000, 6'd0,  1'b0, 6'd0,  32'd0));
    add_row(req_row(CMD_COUNT, 16'd600,  6'd0,  1'b0, 6'd0,  32'd0));
    // writes past the register file must change nothing
    add_row(wr_row(REG_UNUSED_HI, 16'hFFFF));
    add_row(wr_row(REG_UNUSED_LO, 16'h0000));
    add_row(req_row(CMD_COUNT, 16'd600,  6'd0,  1'b0, 6'd0,  32'd0));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE)
        write_reg(dir_rows[i].idx, dir_rows[i].value);
      else
        send_item(dir_rows[i].cmd, dir_rows[i].smp, dir_rows[i].rbin, dir_rows[i].typed,
                  dir_rows[i].want_bin, dir_rows[i].want_total);
    end

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        1: begin
          lo_i = -32768; hi_i = 32767; wid = 1024; nb = 64;
        end
        2: begin
          lo_i = -32768; hi_i = 32767; wid = 65535; nb = 64;
        end
        4: begin
          lo_i = int'($urandom_range(0, 65535)) - 32768;
          hi_i = lo_i - int'($urandom_range(0, 2000));
          if (hi_i < -32768) hi_i = -32768;
          wid  = $urandom_range(1, 4000);
          nb   = $urandom_range(1, 64);
        end
        5: begin
          lo_i = int'($urandom_range(0, 32768)) - 32768;
          hi_i = lo_i + int'($urandom_range(1000, 32767));
          wid  = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(1, 300);
          nb   = ($urandom_range(0, 1) == 1) ? 0 : 127;
        end
        7: begin
          lo_i = int'($urandom_range(0, 65535)) - 32768;
          hi_i = int'($urandom_range(0, 65535)) - 32768;
          wid  = $urandom_range(0, 65535);
          nb   = $urandom_range(0, 65535);
        end
        default: begin
          // well-formed: bins tile the range, width jittered to force overshoot
          nb   = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 8) : $urandom_range(1, 64);
          lo_i = int'($urandom_range(0, 49152)) - 32768;
          span = $urandom_range(nb, 32767 - lo_i);
          hi_i = lo_i + span;
          wid  = (span + nb - 1) / nb + int'($urandom_range(0, 2)) - 1;
          if (wid < 1) wid = 1;
        end
      endcase
      write_reg(REG_LOWER_BOUND, 16'(lo_i));
      write_reg(REG_UPPER_BOUND, 16'(hi_i));
      write_reg(REG_BIN_WIDTH,   16'(wid));
      write_reg(REG_BINS_IN_USE, 16'(nb));
      if (ph == PHASES - 1)
        write_reg(cfg_index_t'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), 16'($urandom));
      // let the block back up behind a stalled result side
      if (ph == 0) hold_request = 1'b1;

      span = hi_i - lo_i;
      if (span < 64) span = 64;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
          send_item(CMD_READ, 16'($urandom), 6'($urandom), 1'b0, '0, '0);
        end else begin
          if (pick < 7)
            s = lo_i + int'($urandom_range(0, span));
          else if (pick == 7)
            s = (($urandom_range(0, 1) == 1) ? lo_i : hi_i) + int'($urandom_range(0, 2)) - 1;
          else
            s = int'($urandom);
          send_item(CMD_COUNT, 16'(s), 6'($urandom), 1'b0, '0, '0);
        end
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_bins.size() != 0) @(posedge clk);
    repeat (48) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
